/* rtl/pls_pkg.sv */
// Shared types and constants for the positional list store.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = 7;
	localparam int POS_W    = 7;
	localparam int OP_W     = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_GET    = 3'd2,
		OP_LOCATE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_BAD_POS = 2'd1,
		STS_FULL    = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		op_t     mode;
		logic    desc;
		logic    scan;
		logic    shift_wr;
		logic    place;
		logic    get_rd;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    cnt_clr;
		logic    respond;
		status_t res_status;
		logic    res_get;
		logic    res_found;
	} pls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad_ins;
		logic bad_acc;
		logic full;
		logic scan_done;
		logic match;
	} pls_flags_t;

endpackage

`default_nettype wire

/* rtl/pls_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on pls_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module pls_ram #(
	parameter int WIDTH = pls_pkg::DATA_W,
	parameter int DEPTH = pls_pkg::CAPACITY
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/pls_ctrl.sv */
// Sequencing state machine for the positional list store.
// Depends on pls_pkg; drives pls_datapath through pls_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module pls_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [pls_pkg::OP_W-1:0] op,
	input  wire pls_pkg::pls_flags_t     flags,
	output pls_pkg::pls_cmd_t            cmd,
	output logic                         busy
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_PLACE = 4'b0100,
		ST_GETW  = 4'b1000
	} state_t;

	state_t         state_q, state_d;
	pls_pkg::op_t   op_q;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op)
						pls_pkg::OP_INSERT: begin
							if (flags.bad_ins) begin
								cmd.respond    = 1'b1;
								cmd.res_status = pls_pkg::STS_BAD_POS;
							end else if (flags.full) begin
								cmd.respond    = 1'b1;
								cmd.res_status = pls_pkg::STS_FULL;
							end else begin
								cmd.load = 1'b1;
								cmd.mode = pls_pkg::OP_INSERT;
								state_d  = ST_SCAN;
							end
						end
						pls_pkg::OP_DELETE: begin
							if (flags.bad_acc) begin
								cmd.respond    = 1'b1;
								cmd.res_status = pls_pkg::STS_BAD_POS;
							end else begin
								cmd.load = 1'b1;
								cmd.mode = pls_pkg::OP_DELETE;
								state_d  = ST_SCAN;
							end
						end
						pls_pkg::OP_GET: begin
							if (flags.bad_acc) begin
								cmd.respond    = 1'b1;
								cmd.res_status = pls_pkg::STS_BAD_POS;
							end else begin
								cmd.get_rd = 1'b1;
								state_d    = ST_GETW;
							end
						end
						pls_pkg::OP_LOCATE: begin
							cmd.load = 1'b1;
							cmd.mode = pls_pkg::OP_LOCATE;
							state_d  = ST_SCAN;
						end
						pls_pkg::OP_CLEAR: begin
							cmd.cnt_clr = 1'b1;
							cmd.respond = 1'b1;
						end
						default: begin
							cmd.respond = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.desc = (op_q == pls_pkg::OP_INSERT);
				if (op_q == pls_pkg::OP_LOCATE && flags.match) begin
					cmd.respond   = 1'b1;
					cmd.res_found = 1'b1;
					state_d       = ST_IDLE;
				end else if (flags.scan_done) begin
					if (op_q == pls_pkg::OP_INSERT) begin
						state_d = ST_PLACE;
					end else begin
						cmd.respond = 1'b1;
						cmd.cnt_dec = (op_q == pls_pkg::OP_DELETE);
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.scan     = 1'b1;
					cmd.shift_wr = (op_q != pls_pkg::OP_LOCATE);
				end
			end
			ST_PLACE: begin
				cmd.place   = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_GETW: begin
				cmd.res_get = 1'b1;
				cmd.respond = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= pls_pkg::OP_INSERT;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= cmd.mode;
			end
		end
	end

`ifndef SYNTHESIS
	// every transaction result ends the operation
	a_respond_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> (state_q == ST_IDLE))
		else $error("respond not followed by idle");

	a_place_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |-> (op_q == pls_pkg::OP_INSERT))
		else $error("place state outside insert");
`endif

endmodule

`default_nettype wire

/* rtl/pls_datapath.sv */
// Datapath: entry RAM, list count, scan pointers and result registers.
// Depends on pls_pkg and pls_ram; commanded by pls_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module pls_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pls_pkg::pls_cmd_t             cmd,
	input  wire logic [pls_pkg::POS_W-1:0]     position,
	input  wire logic [pls_pkg::DATA_W-1:0]    value,
	output pls_pkg::pls_flags_t                flags,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [pls_pkg::DATA_W-1:0]         read_value,
	output logic                               found,
	output logic [pls_pkg::IDX_W-1:0]          found_position,
	output logic [pls_pkg::CNT_W-1:0]          count
);

	localparam int IDX_W = pls_pkg::IDX_W;
	localparam int CNT_W = pls_pkg::CNT_W;
	localparam int DATA_W = pls_pkg::DATA_W;

	logic [CNT_W-1:0]  count_q, count_d, rem_q;
	logic [IDX_W-1:0]  ptr_q, lag_q, pos_q;
	logic              lag_vld_q;
	logic [DATA_W-1:0] value_q, rdata;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata;

	logic              done_q;
	pls_pkg::status_t  res_status_q;
	logic [DATA_W-1:0] res_read_q;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_fpos_q;
	logic [CNT_W-1:0]  res_count_q;

	assign flags.bad_ins   = (position > count_q);
	assign flags.bad_acc   = (position >= count_q);
	assign flags.full      = (count_q >= CNT_W'(pls_pkg::CAPACITY));
	assign flags.scan_done = (rem_q == '0) && !lag_vld_q;
	assign flags.match     = lag_vld_q && (rdata == value_q);

	always_comb begin
		if (cmd.cnt_clr) begin
			count_d = '0;
		end else if (cmd.cnt_inc) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			count_d = count_q - CNT_W'(1);
		end else begin
			count_d = count_q;
		end
	end

	// Shift moves one entry per cycle: the entry read last cycle (lag) is
	// written one slot up (insert) or down (delete) while the next is read.
	assign ram_we    = (cmd.shift_wr && lag_vld_q) || cmd.place;
	assign ram_waddr = cmd.place ? pos_q :
		(cmd.desc ? lag_q + IDX_W'(1) : lag_q - IDX_W'(1));
	assign ram_wdata = cmd.place ? value_q : rdata;
	assign ram_raddr = cmd.get_rd ? position[IDX_W-1:0] : ptr_q;

	pls_ram #(
		.WIDTH(DATA_W),
		.DEPTH(pls_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rem_q     <= '0;
			lag_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= cmd.respond;
			if (cmd.load) begin
				lag_vld_q <= 1'b0;
				case (cmd.mode)
					pls_pkg::OP_INSERT: rem_q <= count_q - position;
					pls_pkg::OP_DELETE: rem_q <= count_q - position - CNT_W'(1);
					default:            rem_q <= count_q;
				endcase
			end else if (cmd.scan) begin
				if (rem_q != '0) begin
					rem_q     <= rem_q - CNT_W'(1);
					lag_vld_q <= 1'b1;
				end else begin
					lag_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= position[IDX_W-1:0];
			value_q <= value;
			case (cmd.mode)
				pls_pkg::OP_INSERT: ptr_q <= IDX_W'(count_q - CNT_W'(1));
				pls_pkg::OP_DELETE: ptr_q <= IDX_W'(position + CNT_W'(1));
				default:            ptr_q <= '0;
			endcase
		end else if (cmd.scan && rem_q != '0) begin
			lag_q <= ptr_q;
			ptr_q <= cmd.desc ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
		end
		if (cmd.respond) begin
			res_status_q <= cmd.res_status;
			res_read_q   <= cmd.res_get ? rdata : '0;
			res_found_q  <= cmd.res_found;
			res_fpos_q   <= cmd.res_found ? lag_q : '0;
			res_count_q  <= count_d;
		end
	end

	assign done           = done_q;
	assign status         = res_status_q;
	assign read_value     = res_read_q;
	assign found          = res_found_q;
	assign found_position = res_fpos_q;
	assign count          = res_count_q;

`ifndef SYNTHESIS
	// writes stay inside the list or one slot past its end
	a_waddr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= count_q))
		else $error("entry write beyond list end");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (count_q == res_count_q))
		else $error("reported count differs from held count");
`endif

endmodule

`default_nettype wire

/* rtl/positional_list_store.sv */
// Positional list store: ordered list of signed 32-bit entries with insert, delete,
// get by position, locate by value, and clear. Reset (arst_n) clears count and control.
// Clear, unused ops and rejected requests answer straight from idle; get reads the RAM,
// then answers; insert moves the entries from the end back to the position up one slot,
// then writes the new one; delete moves later entries down; locate stops at its first hit.
// One entry moved or compared per cycle; busy drops in the done cycle. No output stall.
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [pls_pkg::OP_W-1:0]       op,
	input  wire logic [pls_pkg::POS_W-1:0]      position,
	input  wire logic signed [pls_pkg::DATA_W-1:0] value,
	output logic                                busy,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [pls_pkg::DATA_W-1:0]   read_value,
	output logic                                found,
	output logic [pls_pkg::IDX_W-1:0]           found_position,
	output logic [pls_pkg::CNT_W-1:0]           count
);

	pls_pkg::pls_cmd_t           cmd;
	pls_pkg::pls_flags_t         flags;
	logic [pls_pkg::DATA_W-1:0]  rd_val;

	pls_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (op),
		.flags (flags),
		.cmd   (cmd),
		.busy  (busy)
	);

	pls_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.position      (position),
		.value         ($unsigned(value)),
		.flags         (flags),
		.done          (done),
		.status        (status),
		.read_value    (rd_val),
		.found         (found),
		.found_position(found_position),
		.count         (count)
	);

	assign read_value = $signed(rd_val);

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for positional_list_store: directed and random list transactions.
// Depends on rtl/pls_pkg.sv and rtl/positional_list_store.sv.
`timescale 1ns / 1ps

module tb_top;

	import pls_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
	localparam int POS_MAX       = 127;
	localparam int STALL_LIMIT   = 2000;
	localparam int TAIL_CYCLES   = 100;
	localparam int PHASE_ITEMS   = 175;
	localparam int POOL_DEPTH    = 32;

	typedef struct {
		logic [OP_W-1:0]         opc;
		logic [POS_W-1:0]        pos;
		logic signed [DATA_W-1:0] val;
		int                      idle_pct;
		bit                      drain;
	} list_req_t;

	typedef struct {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] rd;
		logic                     fnd;
		logic [IDX_W-1:0]         fpos;
		logic [CNT_W-1:0]         cnt;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] op = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic busy;
	logic done;
	logic [1:0] status;
	logic signed [DATA_W-1:0] read_value;
	logic found;
	logic [IDX_W-1:0] found_position;
	logic [CNT_W-1:0] count;

	positional_list_store dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.op             (op),
		.position       (position),
		.value          (value),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.read_value     (read_value),
		.found          (found),
		.found_position (found_position),
		.count          (count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// pending transactions and outstanding results
	list_req_t    pending_q[$];
	list_result_t outstanding_q[$];
	int total_reqs = 0;
	int issued_cnt = 0;
	int accepted_cnt = 0;
	int errors = 0;
	int stall_cycles = 0;
	bit holding = 1'b0;

	// shadow list for prediction
	logic signed [DATA_W-1:0] list_mem [0:CAPACITY-1];
	int list_len = 0;

	// generator bookkeeping
	int gen_len = 0;
	int useful_cnt = 0;
	int cur_idle = 0;
	logic signed [DATA_W-1:0] value_pool[$];

	function automatic list_result_t apply_request(logic [OP_W-1:0] opc, logic [POS_W-1:0] pos,
			logic signed [DATA_W-1:0] val);
		list_result_t r;
		int i;
		r.status = STS_OK;
		r.rd = '0;
		r.fnd = 1'b0;
		r.fpos = '0;
		case (opc)
			OP_INSERT: begin
				if (pos > list_len)
					r.status = STS_BAD_POS;
				else if (list_len >= CAPACITY)
					r.status = STS_FULL;
				else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			OP_DELETE: begin
				if (pos >= list_len)
					r.status = STS_BAD_POS;
				else begin
					for (i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			OP_GET: begin
				if (pos >= list_len)
					r.status = STS_BAD_POS;
				else
					r.rd = list_mem[pos];
			end
			OP_LOCATE: begin
				for (i = list_len - 1; i >= 0; i--) begin
					if (list_mem[i] == val) begin
						r.fnd = 1'b1;
						r.fpos = IDX_W'(i);
					end
				end
			end
			OP_CLEAR: list_len = 0;
			default: ;
		endcase
		r.cnt = CNT_W'(list_len);
		return r;
	endfunction

	task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	task automatic add_req(input logic [OP_W-1:0] opc, input int pos,
			input logic signed [DATA_W-1:0] val);
		list_req_t r;
		r.opc = opc;
		r.pos = POS_W'(pos);
		r.val = val;
		r.idle_pct = cur_idle;
		r.drain = 1'b0;
		pending_q = {pending_q, r};
		total_reqs++;
		case (opc)
			OP_INSERT: begin
				if (pos <= gen_len && gen_len < CAPACITY)
					gen_len++;
				value_pool = {value_pool, val};
				if (value_pool.size() > POOL_DEPTH)
					void'(value_pool.pop_front());
			end
			OP_DELETE: if (pos < gen_len) gen_len--;
			OP_CLEAR: gen_len = 0;
			default: ;
		endcase
		if (opc <= OP_CLEAR)
			useful_cnt++;
	endtask

	// hold the sender back until every outstanding result is in
	task automatic add_drain();
		list_req_t r;
		r.opc = OP_GET;
		r.pos = '0;
		r.val = '0;
		r.idle_pct = 0;
		r.drain = 1'b1;
		pending_q = {pending_q, r};
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		int k;
		k = $urandom_range(9);
		case (k)
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3: return $signed(32'($urandom_range(7))) - 32'sd3;   // small values repeat often
			4, 5: begin
				if (value_pool.size() != 0)
					return value_pool[$urandom_range(value_pool.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic random_step();
		int k;
		int bad;
		k = $urandom_range(99);
		bad = ($urandom_range(99) < 8);
		if (k < 36) begin
			if (bad)
				add_req(OP_INSERT, $urandom_range(POS_MAX, gen_len + 1), pick_value());
			else
				add_req(OP_INSERT, $urandom_range(gen_len), pick_value());
		end else if (k < 61) begin
			if (bad || gen_len == 0)
				add_req(OP_DELETE, $urandom_range(POS_MAX, gen_len), $urandom);
			else
				add_req(OP_DELETE, $urandom_range(gen_len - 1), $urandom);
		end else if (k < 76) begin
			if (bad || gen_len == 0)
				add_req(OP_GET, $urandom_range(POS_MAX, gen_len), $urandom);
			else
				add_req(OP_GET, $urandom_range(gen_len - 1), $urandom);
		end else if (k < 91)
			add_req(OP_LOCATE, $urandom_range(POS_MAX), pick_value());
		else if (k < 93)
			add_req(OP_CLEAR, $urandom_range(POS_MAX), $urandom);
		else if (k < 95)
			add_req(OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)),
				$urandom_range(POS_MAX), $urandom);
		else
			add_req(OP_W'($urandom_range(OP_SPARE_LAST)), $urandom_range(POS_MAX), $urandom);
	endtask

	// run the list up to capacity, then hit the full and past-end cases
	task automatic fill_list();
		while (gen_len < CAPACITY)
			add_req(OP_INSERT, $urandom_range(gen_len), pick_value());
		add_req(OP_INSERT, CAPACITY, pick_value());
		add_req(OP_INSERT, CAPACITY + 1, pick_value());
		add_req(OP_INSERT, 0, pick_value());
		add_req(OP_GET, CAPACITY - 1, $urandom);
		add_req(OP_GET, CAPACITY, $urandom);
		add_req(OP_LOCATE, 0, pick_value());
		add_req(OP_DELETE, CAPACITY - 1, $urandom);
		add_req(OP_DELETE, 0, $urandom);
	endtask

	always @(negedge clk) begin : drive_requests
		list_req_t nxt;
		if (!arst_n)
			start <= 1'b0;
		else begin
			if (holding && accepted_cnt == issued_cnt)
				holding = 1'b0;
			if (!holding) begin
				while (pending_q.size() != 0 && pending_q[0].drain && outstanding_q.size() == 0)
					nxt = pending_q.pop_front();
				if (pending_q.size() != 0 && !pending_q[0].drain &&
						$urandom_range(99) >= pending_q[0].idle_pct) begin
					nxt = pending_q.pop_front();
					op <= nxt.opc;
					position <= nxt.pos;
					value <= nxt.val;
					start <= 1'b1;
					holding = 1'b1;
					issued_cnt++;
				end else
					start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : watch_results
		list_result_t want;
		list_result_t pred;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (done) begin
				moved = 1'b1;
				if (outstanding_q.size() == 0) begin
					errors++;
					$display("%0t: result with no outstanding transaction", $time);
				end else begin
					want = outstanding_q.pop_front();
					if (status !== want.status)
						report("status", 64'(want.status), 64'(status));
					if (read_value !== want.rd)
						report("read_value", 64'(want.rd), 64'(read_value));
					if (found !== want.fnd)
						report("found", 64'(want.fnd), 64'(found));
					if (found_position !== want.fpos)
						report("found_position", 64'(want.fpos), 64'(found_position));
					if (count !== want.cnt)
						report("count", 64'(want.cnt), 64'(count));
				end
			end
			if (start && !busy) begin
				moved = 1'b1;
				pred = apply_request(op, position, value);
				outstanding_q = {outstanding_q, pred};
				accepted_cnt++;
			end
			if (moved)
				stall_cycles = 0;
			else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int ph;
		int idle_table [0:3];
		int target;
		idle_table[0] = 0;
		idle_table[1] = 68;
		idle_table[2] = 0;
		idle_table[3] = 26;

		// directed: empty-list cases, extremes, duplicates, spare ops, clear
		cur_idle = 0;
		add_req(OP_LOCATE, 0, 32'sd0);
		add_req(OP_GET, 0, 32'sd0);
		add_req(OP_DELETE, 0, 32'sd0);
		add_req(OP_INSERT, 1, 32'sd5);
		add_req(OP_INSERT, POS_MAX, 32'sd5);
		add_req(OP_INSERT, 0, 32'sh7FFFFFFF);
		add_req(OP_INSERT, 1, 32'sh80000000);
		add_req(OP_INSERT, 0, 32'sd0);
		add_req(OP_INSERT, 4, 32'sd9);
		add_req(OP_INSERT, 1, -32'sd1);
		add_req(OP_INSERT, 4, 32'sh7FFFFFFF);
		add_req(OP_GET, 0, 32'sd0);
		add_req(OP_GET, 4, 32'sd0);
		add_req(OP_GET, 5, 32'sd0);
		add_req(OP_LOCATE, 0, 32'sh7FFFFFFF);
		add_req(OP_LOCATE, 0, 32'sh80000000);
		add_req(OP_LOCATE, 0, 32'sd12345);
		add_req(OP_DELETE, 4, 32'sd0);
		add_req(OP_DELETE, 0, 32'sd0);
		add_req(OP_DELETE, 3, 32'sd0);
		add_req(OP_SPARE_FIRST, 0, 32'sd0);
		add_req(OP_SPARE_FIRST + 3'd1, POS_MAX, -32'sd1);
		add_req(OP_SPARE_LAST, 3, 32'sh7FFFFFFF);
		add_req(OP_CLEAR, 0, 32'sd0);
		add_req(OP_GET, 0, 32'sd0);
		add_req(OP_LOCATE, 0, -32'sd1);

		target = useful_cnt;
		for (ph = 0; ph < 4; ph++) begin
			add_drain();
			cur_idle = idle_table[ph];
			target += PHASE_ITEMS;
			if (ph % 2 == 0)
				fill_list();
			while (useful_cnt < target)
				random_step();
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt != total_reqs)
			@(posedge clk);
		while (outstanding_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
